/* hdl/rbam_pkg.sv */
package rbam_pkg;

    // ring geometry
    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);

    // field widths
    localparam int SAMPLE_W = 14;
    localparam int RAW_W    = 8;
    localparam int VOL_W    = 7;
    localparam int FILL_W   = 12;

    // full-scale mix weight and the matching shift
    localparam int VOL_FULL   = 64;
    localparam int MIX_SHIFT  = 6;

    // stream widths
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 32;

    // command codes carried on s_tuser
    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_PULL = 1'b1;

    // fill level reported when the ring holds its maximum
    localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH - 1);

    // request in flight between the memory read and the write back
    typedef struct packed {
        logic                       is_pull;
        logic                       do_mix;
        logic                       do_write;
        logic [ADDR_W-1:0]          addr;
        logic signed [SAMPLE_W-1:0] scaled;
        logic [VOL_W:0]             wgt_old;
        logic                       hit;
        logic                       ovf;
        logic [FILL_W-1:0]          fill;
    } stage_t;

endpackage

/* hdl/ring_buffer_audio_mixer_top.sv */
// channel   dir  fields (lowest bit first)
// s_*       in   tuser: cmd; tdata: raw_sample[7:0], volume[14:8], first_of_sound[15]
// m_*       out  tdata: out_sample[13:0], out_valid[14], overflow[15], fill_level[27:16]
//
// one request per cycle while no result is stalled; a result passes the s1 stage, then the output register
// the sample ring is one memory with a registered read; an add mixes in the stage
// after the read and writes back as that stage advances, with one-deep forwarding
// rst_n clears pointers and counts at once; the ring itself is not cleared
// a stalled result holds the write-back stage, and s_tready drops only then
module ring_buffer_audio_mixer_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [rbam_pkg::IN_TDATA_W-1:0] s_tdata,  // raw_sample, volume, first_of_sound
    input  logic                           s_tuser,  // cmd
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [rbam_pkg::OUT_TDATA_W-1:0] m_tdata  // out_sample, out_valid, overflow,
                                                      // fill_level
);
    import rbam_pkg::*;

    // ring memory
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];

    // control state
    logic [ADDR_W-1:0] play_reg, play_next;
    logic [ADDR_W-1:0] count_reg, count_next;
    logic [ADDR_W-1:0] offset_reg, offset_next;

    // pipeline registers
    logic                       s1_valid_reg;
    stage_t                     s1_reg, s1_next;
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                       fwd_hit_reg, fwd_hit_next;
    logic signed [SAMPLE_W-1:0] fwd_data_reg;
    logic                       out_valid_reg;
    logic [OUT_TDATA_W-1:0]     out_data_reg, out_data_next;

    logic                       accept;
    logic                       out_adv;
    logic [ADDR_W-1:0]          rd_addr;

    // input fields
    logic [RAW_W-1:0]           raw_sample;
    logic [VOL_W-1:0]           volume;
    logic                       first_of_sound;
    logic [VOL_W-1:0]           vol_sat;
    logic signed [SAMPLE_W-1:0] centered;
    logic signed [21:0]         new_prod;
    logic [ADDR_W-1:0]          off_base;
    logic [ADDR_W-1:0]          off_clamp;

    // write-back stage
    logic signed [SAMPLE_W-1:0] old_val;
    logic signed [21:0]         old_prod;
    logic signed [15:0]         mix_sum;
    logic signed [SAMPLE_W-1:0] wr_data;
    logic signed [SAMPLE_W-1:0] out_sample;

    function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] a,
                                                   input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] sum;
        begin
            sum = {1'b0, a} + {1'b0, b};
            if (sum >= (ADDR_W+1)'(RING_DEPTH))
            begin
                sum = sum - (ADDR_W+1)'(RING_DEPTH);
            end
            return sum[ADDR_W-1:0];
        end
    endfunction

    // handshake
    assign out_adv  = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || out_adv;
    assign accept   = s_tvalid && s_tready;

    assign raw_sample     = s_tdata[RAW_W-1:0];
    assign volume         = s_tdata[RAW_W+VOL_W-1:RAW_W];
    assign first_of_sound = s_tdata[RAW_W+VOL_W];

    // widen and scale the new sample
    always_comb
    begin
        vol_sat  = (volume > VOL_W'(VOL_FULL)) ? VOL_W'(VOL_FULL) : volume;
        centered = {~raw_sample[RAW_W-1], raw_sample[RAW_W-2:0], 6'b0};
        new_prod = centered * $signed({1'b0, vol_sat});
        off_base = first_of_sound ? '0 : offset_reg;
        off_clamp = (off_base > count_reg) ? count_reg : off_base;
    end

    // pointer and count update, read address
    always_comb
    begin
        play_next    = play_reg;
        count_next   = count_reg;
        offset_next  = offset_reg;
        rd_addr      = play_reg;
        s1_next      = '0;
        s1_next.scaled  = SAMPLE_W'(new_prod >>> MIX_SHIFT);
        s1_next.wgt_old = (VOL_W+1)'(VOL_FULL) - {1'b0, vol_sat};
        if (s_tuser == CMD_PULL)
        begin
            s1_next.is_pull = 1'b1;
            if (count_reg != '0)
            begin
                s1_next.hit = 1'b1;
                play_next   = wrap_add(play_reg, ADDR_W'(1));
                count_next  = count_reg - ADDR_W'(1);
                if (offset_reg != '0)
                begin
                    offset_next = offset_reg - ADDR_W'(1);
                end
            end
        end
        else
        begin
            offset_next = off_clamp;
            if (off_clamp < count_reg)
            begin
                rd_addr          = wrap_add(play_reg, off_clamp);
                s1_next.do_mix   = 1'b1;
                s1_next.do_write = 1'b1;
                offset_next      = off_clamp + ADDR_W'(1);
            end
            else if (count_reg < ADDR_W'(RING_DEPTH - 1))
            begin
                rd_addr          = wrap_add(play_reg, count_reg);
                s1_next.do_write = 1'b1;
                count_next       = count_reg + ADDR_W'(1);
                offset_next      = off_clamp + ADDR_W'(1);
            end
            else
            begin
                s1_next.ovf = 1'b1;
            end
        end
        s1_next.addr = rd_addr;
        s1_next.fill = FILL_W'(count_next);
        // the write retiring at the same edge is not yet visible in the read
        fwd_hit_next = out_adv && s1_reg.do_write && (s1_reg.addr == rd_addr);
    end

    // mix and write-back value
    always_comb
    begin
        old_val  = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        old_prod = old_val * $signed({1'b0, s1_reg.wgt_old});
        mix_sum  = 16'(old_prod >>> MIX_SHIFT) + 16'(s1_reg.scaled);
        wr_data  = s1_reg.do_mix ? mix_sum[SAMPLE_W-1:0] : s1_reg.scaled;
        out_sample = (s1_reg.is_pull && s1_reg.hit) ? old_val : '0;
        out_data_next = {4'b0, s1_reg.fill, s1_reg.ovf,
                         s1_reg.is_pull && s1_reg.hit, out_sample};
    end

    // ring memory, read first
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= ring_mem[rd_addr];
        end
        if (out_adv && s1_reg.do_write)
        begin
            ring_mem[s1_reg.addr] <= wr_data;
        end
    end

    // pipeline payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg       <= s1_next;
            fwd_hit_reg  <= fwd_hit_next;
            fwd_data_reg <= wr_data;
        end
        if (out_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            play_reg      <= '0;
            count_reg     <= '0;
            offset_reg    <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                play_reg   <= play_next;
                count_reg  <= count_next;
                offset_reg <= offset_next;
            end
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

/* hdl/rbam_checker.sv */
module rbam_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rbam_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rbam_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a dropped sample only when the ring is full, never with a sample
    a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[15] |-> m_tdata[27:16] == FILL_FULL && !m_tdata[14])
        else $error("overflow without a full ring");

    // no sample value without a pulled sample
    a_zero_sample: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[14] |-> m_tdata[13:0] == '0)
        else $error("sample value on a result with no pulled sample");

    // a pull frees a slot, so the ring cannot read full afterwards
    a_pull_fill: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[14] |-> m_tdata[27:16] != FILL_FULL)
        else $error("fill level full after a pull");

endmodule

bind ring_buffer_audio_mixer_top rbam_checker u_rbam_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

/* sim/rbam_mix_check.sv */
module rbam_mix_check (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [rbam_pkg::IN_TDATA_W-1:0]  s_tdata,   // raw_sample, volume, first_of_sound
    input  logic                             s_tuser,   // cmd
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [rbam_pkg::OUT_TDATA_W-1:0] m_tdata,   // out_sample, out_valid, overflow,
                                                        // fill_level
    output int                               results_done,
    output int                               mix_errors
);
    timeunit 1ns;
    timeprecision 1ps;
    import rbam_pkg::*;

    // offset that centres an unsigned byte once it is scaled by full volume
    localparam int CENTRE = 1 << (RAW_W + MIX_SHIFT - 1);

    typedef struct {
        logic [SAMPLE_W-1:0] sample;
        logic                valid;
        logic                ovf;
        logic [FILL_W-1:0]   fill;
    } mix_out_t;

    // shadow of the ring and its pointers
    logic signed [SAMPLE_W-1:0] ring_mem [RING_DEPTH];
    logic [ADDR_W-1:0]          play_ptr;
    int                         queued;
    int                         snd_offset;

    mix_out_t mix_expect_q[$];

    // apply one request to the shadow ring and return the result it should give
    function automatic mix_out_t mix_predict(input logic cmd, input logic [RAW_W-1:0] raw,
                                             input logic [VOL_W-1:0] vol, input logic first);
        mix_out_t          r;
        logic [ADDR_W-1:0] slot;
        int                centred;
        int                weight;
        int                prev;
        int                mixed;
        r.sample = '0;
        r.valid  = 1'b0;
        r.ovf    = 1'b0;
        if (cmd == CMD_PULL)
        begin
            if (queued != 0)
            begin
                r.sample = ring_mem[play_ptr];
                r.valid  = 1'b1;
                play_ptr = play_ptr + ADDR_W'(1);
                queued--;
                if (snd_offset != 0)
                    snd_offset--;
            end
        end
        else
        begin
            centred = int'(raw) * VOL_FULL - CENTRE;
            weight  = (int'(vol) > VOL_FULL) ? VOL_FULL : int'(vol);
            if (first)
                snd_offset = 0;
            if (snd_offset > queued)
                snd_offset = queued;
            if (snd_offset < queued)
            begin
                // lands on a queued sample: cross-fade with what is there
                slot  = play_ptr + ADDR_W'(snd_offset);
                prev  = int'(ring_mem[slot]);
                mixed = ((prev * (VOL_FULL - weight)) >>> MIX_SHIFT)
                      + ((centred * weight) >>> MIX_SHIFT);
                ring_mem[slot] = SAMPLE_W'(mixed);
                snd_offset++;
            end
            else if (queued < RING_DEPTH - 1)
            begin
                // past the queue: append the scaled sample
                slot  = play_ptr + ADDR_W'(queued);
                mixed = (centred * weight) >>> MIX_SHIFT;
                ring_mem[slot] = SAMPLE_W'(mixed);
                queued++;
                snd_offset++;
            end
            else
            begin
                r.ovf = 1'b1;
            end
        end
        r.fill = FILL_W'(queued);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [SAMPLE_W-1:0] want,
                               input logic [SAMPLE_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
            mix_errors++;
        end
    endtask

    // compare each result with the oldest expectation, then predict new requests
    always @(posedge clk or negedge rst_n)
    begin
        mix_out_t want;
        if (!rst_n)
        begin
            play_ptr     = '0;
            queued       = 0;
            snd_offset   = 0;
            results_done = 0;
            mix_errors   = 0;
            mix_expect_q.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (mix_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %0h",
                             $time, m_tdata);
                    mix_errors++;
                end
                else
                begin
                    want = mix_expect_q.pop_front();
                    results_done++;
                    check_field("out_sample", want.sample, m_tdata[SAMPLE_W-1:0]);
                    check_field("out_valid", SAMPLE_W'(want.valid),
                                SAMPLE_W'(m_tdata[SAMPLE_W]));
                    check_field("overflow", SAMPLE_W'(want.ovf),
                                SAMPLE_W'(m_tdata[SAMPLE_W+1]));
                    check_field("fill_level", SAMPLE_W'(want.fill),
                                SAMPLE_W'(m_tdata[SAMPLE_W+2 +: FILL_W]));
                end
            end
            if (s_tvalid && s_tready)
                mix_expect_q.push_back(mix_predict(s_tuser, s_tdata[RAW_W-1:0],
                                                   s_tdata[RAW_W +: VOL_W],
                                                   s_tdata[RAW_W+VOL_W]));
        end
    end

endmodule

/* sim/ring_buffer_audio_mixer_top_test.sv */
module ring_buffer_audio_mixer_top_test;
    timeunit 1ns;
    timeprecision 1ps;
    import rbam_pkg::*;

    localparam int RAND_REQS   = 1760;
    localparam int HOLD_CYCLES = 400;
    localparam int HOLD_REQS   = 80;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 800000;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    int results_done;
    int mix_errors;
    int reqs_sent  = 0;
    int cycle_cnt  = 0;
    int burst_left = 0;
    bit gapless    = 1'b0;
    bit hold_req   = 1'b0;

    ring_buffer_audio_mixer_top uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    rbam_mix_check mix_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .results_done (results_done),
        .mix_errors   (mix_errors)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // offer one request, in bursts with random gaps, and wait until it is taken
    task automatic push_req(input logic cmd, input logic [RAW_W-1:0] raw,
                            input logic [VOL_W-1:0] vol, input logic first);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = (gapless || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {first, vol, raw};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        reqs_sent++;
    endtask

    // pull request with noise in the fields it does not use
    task automatic pull_one();
        push_req(CMD_PULL, RAW_W'($urandom_range(0, 255)), VOL_W'($urandom_range(0, 127)),
                 1'($urandom_range(0, 1)));
    endtask

    // stop offering until every request has produced its result
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (results_done == reqs_sent);
    endtask

    // one sound: a run of adds at one volume, with pulls mixed in
    task automatic play_sound(input int len);
        logic [VOL_W-1:0] vol;
        int               pick;
        int               k;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            vol = '0;
        else if (pick == 1)
            vol = VOL_W'(VOL_FULL);
        else if (pick == 2)
            vol = VOL_W'($urandom_range(VOL_FULL + 1, 127));
        else
            vol = VOL_W'($urandom_range(1, VOL_FULL - 1));
        for (k = 0; k < len; k++)
        begin
            if ($urandom_range(0, 3) == 0)
                pull_one();
            push_req(CMD_ADD, RAW_W'($urandom_range(0, 255)), vol, k == 0);
        end
    endtask

    // receiver: ready patterns that change now and then, plus one long hold-off
    initial
    begin : rx_pattern
        int         mode;
        int         mode_left;
        logic [7:0] pat;
        mode      = 0;
        mode_left = 0;
        pat       = 8'hb6;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = $urandom_range(0, 2);
                    mode_left = $urandom_range(10, 150);
                    pat       = 8'($urandom_range(1, 255));
                end
                mode_left--;
                pat = {pat[6:0], pat[7]};
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= ($urandom_range(0, 99) < 60);
                    default: m_tready <= pat[0];
                endcase
            end
        end
    end

    // run limit
    initial
    begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("ring_buffer_audio_mixer_top_test: done, errors");
        $finish;
    end

    initial
    begin : stimulus
        int  i;
        int  pick;
        int  rand_base;
        bit  hold_done;
        bit  pause_done;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // pull from an empty ring
        pull_one();
        // extremes of sample and volume, saturating volume
        push_req(CMD_ADD, 8'd0, 7'd64, 1'b1);
        push_req(CMD_ADD, 8'd255, 7'd64, 1'b0);
        push_req(CMD_ADD, 8'd128, 7'd0, 1'b0);
        push_req(CMD_ADD, 8'd200, 7'd127, 1'b0);
        push_req(CMD_ADD, 8'd17, 7'd65, 1'b0);
        // new sound restarts at the play position and mixes over the queue
        push_req(CMD_ADD, 8'd0, 7'd1, 1'b1);
        push_req(CMD_ADD, 8'd255, 7'd63, 1'b0);
        push_req(CMD_ADD, 8'd0, 7'd0, 1'b0);
        push_req(CMD_ADD, 8'd255, 7'd64, 1'b0);
        push_req(CMD_ADD, 8'd3, 7'd32, 1'b0);
        // runs past the queue and appends
        push_req(CMD_ADD, 8'd90, 7'd50, 1'b0);
        // pull during a sound keeps it aligned
        pull_one();
        push_req(CMD_ADD, 8'd255, 7'd64, 1'b0);
        // drain, then pull while empty so the offset saturates at zero
        for (i = 0; i < 8; i++)
            pull_one();
        push_req(CMD_ADD, 8'd1, 7'd64, 1'b0);
        pull_one();
        wait_drained();

        // random sounds, pull runs and noise
        rand_base  = reqs_sent;
        hold_done  = 1'b0;
        pause_done = 1'b0;
        while (reqs_sent - rand_base < RAND_REQS)
        begin
            if (!hold_done && reqs_sent - rand_base > RAND_REQS / 2)
            begin
                // receiver holds off while requests keep coming
                hold_done = 1'b1;
                hold_req  = 1'b1;
                gapless   = 1'b1;
                play_sound(HOLD_REQS);
                gapless   = 1'b0;
            end
            if (!pause_done && reqs_sent - rand_base > (RAND_REQS * 3) / 4)
            begin
                pause_done = 1'b1;
                wait_drained();
            end
            pick = $urandom_range(0, 99);
            if (pick < 65)
            begin
                play_sound($urandom_range(1, 48));
            end
            else if (pick < 85)
            begin
                repeat ($urandom_range(1, 24)) pull_one();
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                    push_req(1'($urandom_range(0, 1)), RAW_W'($urandom_range(0, 255)),
                             VOL_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mix_errors == 0)
            $display("ring_buffer_audio_mixer_top_test: done, clean");
        else
            $display("ring_buffer_audio_mixer_top_test: done, errors");
        $finish;
    end

endmodule
